@@ hw/rtl/num7seg_pkg.sv @@
// Shared constants, types and lookup functions for the seven-segment number decoder.
// Used by every module of the block; depends on nothing else.
package num7seg_pkg;

    localparam int MAX_DIGITS_DEF = 8;
    localparam int WORD_DIGITS    = 8;
    localparam int WORD_W         = 8 * WORD_DIGITS;

    localparam int BCD_DIGITS = 8;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIN_W      = 27;
    localparam int DABBLE_STEPS      = 7;
    localparam int DABBLE_STEPS_LAST = BIN_W - 3 * DABBLE_STEPS;

    localparam logic [7:0] SEG_BLANK = 8'b0000_0000;
    localparam logic [7:0] SEG_DASH  = 8'b0100_0000;
    localparam logic [7:0] SEG_POINT = 8'b1000_0000;

    typedef logic [4:0] t_code;
    localparam t_code CODE_BLANK = 5'd16;
    localparam t_code CODE_DASH  = 5'd17;

    typedef logic [0:0] t_reg_addr;
    localparam t_reg_addr REG_DIGITS_IN_USE      = 1'b0;
    localparam t_reg_addr REG_SHOW_LEADING_ZEROS = 1'b1;

    function automatic logic [7:0] glyph(input t_code code);
        logic [7:0] seg;
        unique case (code)
            5'd0:       seg = 8'h3F;
            5'd1:       seg = 8'h06;
            5'd2:       seg = 8'h5B;
            5'd3:       seg = 8'h4F;
            5'd4:       seg = 8'h66;
            5'd5:       seg = 8'h6D;
            5'd6:       seg = 8'h7D;
            5'd7:       seg = 8'h07;
            5'd8:       seg = 8'h7F;
            5'd9:       seg = 8'h6F;
            5'd10:      seg = 8'h77;
            5'd11:      seg = 8'h7C;
            5'd12:      seg = 8'h39;
            5'd13:      seg = 8'h5E;
            5'd14:      seg = 8'h79;
            5'd15:      seg = 8'h71;
            CODE_DASH:  seg = SEG_DASH;
            default:    seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // Largest magnitude that fits in cnt digits of the chosen base.
    function automatic logic [31:0] digit_max(input logic hex, input logic [3:0] cnt);
        logic [31:0] m;
        if (hex) begin
            case (cnt)
                4'd0:    m = 32'h0000_0000;
                4'd1:    m = 32'h0000_000F;
                4'd2:    m = 32'h0000_00FF;
                4'd3:    m = 32'h0000_0FFF;
                4'd4:    m = 32'h0000_FFFF;
                4'd5:    m = 32'h000F_FFFF;
                4'd6:    m = 32'h00FF_FFFF;
                4'd7:    m = 32'h0FFF_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
        end else begin
            case (cnt)
                4'd0:    m = 32'd0;
                4'd1:    m = 32'd9;
                4'd2:    m = 32'd99;
                4'd3:    m = 32'd999;
                4'd4:    m = 32'd9999;
                4'd5:    m = 32'd99999;
                4'd6:    m = 32'd999999;
                4'd7:    m = 32'd9999999;
                default: m = 32'd99999999;
            endcase
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/num7seg_dabble.sv @@
// One registered slice of the shift-and-add-3 binary to BCD converter.
// Depends on num7seg_pkg for the BCD and binary widths.
module num7seg_dabble
    import num7seg_pkg::*;
#(
    parameter int STEPS = DABBLE_STEPS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [BCD_W-1:0] i_bcd,
    input  logic [BIN_W-1:0] i_bin,
    output logic [BCD_W-1:0] o_bcd,
    output logic [BIN_W-1:0] o_bin
);

    logic [BCD_W-1:0] r_bcd;
    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] n_bcd;
    logic [BIN_W-1:0] n_bin;

    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[BIN_W-1]};
            n_bin = {n_bin[BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_bcd = r_bcd;
    assign o_bin = r_bin;

endmodule

@@ hw/rtl/number_to_seven_segment.sv @@
// Throughput is one beat per cycle while i_stall is low, set by the six-stage pipeline (sign,
// range check and BCD slices, then formatting).
// Each stage moves when it is empty or the stage after it moves, so bubbles are squeezed out.
// Reset is synchronous, active low: it empties the pipeline and sets four digits in use with
// leading zeros blanked.
// Depends on num7seg_pkg and num7seg_dabble.
module number_to_seven_segment
    import num7seg_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  t_reg_addr          i_cfg_addr,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    input  logic signed [4:0]  i_point_position,
    input  logic               i_hex_mode,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_segment_word
);

    localparam int NSTAGE = 6;
    localparam int LAST_DABBLE = 5;

    logic [3:0]        r_digits;
    logic              r_zeros;
    logic [NSTAGE:1]   r_vld;
    logic [NSTAGE+1:1] adv;

    logic              r_neg  [1:LAST_DABBLE];
    logic              r_hex  [1:LAST_DABBLE];
    logic signed [4:0] r_pp   [1:LAST_DABBLE];
    logic [31:0]       r_mag  [1:LAST_DABBLE];
    logic              r_fits [2:LAST_DABBLE];

    logic [BCD_W-1:0]  w_bcd [1:LAST_DABBLE];
    logic [BIN_W-1:0]  w_bin [1:LAST_DABBLE];

    logic [3:0]        n_cnt;
    logic              n_fits;
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= 4'd4;
            r_zeros  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_DIGITS_IN_USE:      r_digits <= i_cfg_wdata;
                REG_SHOW_LEADING_ZEROS: r_zeros  <= i_cfg_wdata[0];
                default:                r_zeros  <= r_zeros;
            endcase
        end
    end

    always_comb begin
        if (r_digits == 4'd0) begin
            n_cnt = 4'd1;
        end else if (r_digits > 4'(MAX_DIGITS)) begin
            n_cnt = 4'(MAX_DIGITS);
        end else begin
            n_cnt = r_digits;
        end
    end

    always_comb begin
        adv[NSTAGE+1] = !i_stall;
        for (int k = NSTAGE; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_neg[1] <= i_value[31];
            r_hex[1] <= i_hex_mode;
            r_pp[1]  <= i_point_position;
            r_mag[1] <= i_value[31] ? (~i_value + 32'd1) : i_value;
        end
        for (int k = 2; k <= LAST_DABBLE; k++) begin
            if (adv[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_hex[k] <= r_hex[k-1];
                r_pp[k]  <= r_pp[k-1];
                r_mag[k] <= r_mag[k-1];
            end
        end
        if (adv[2]) begin
            r_fits[2] <= n_fits;
        end
        for (int k = 3; k <= LAST_DABBLE; k++) begin
            if (adv[k]) begin
                r_fits[k] <= r_fits[k-1];
            end
        end
    end

    always_comb begin
        if (r_neg[1]) begin
            n_fits = r_mag[1] <= digit_max(r_hex[1], n_cnt - 4'd1);
        end else begin
            n_fits = r_mag[1] <= digit_max(r_hex[1], n_cnt);
        end
    end

    assign w_bcd[1] = '0;
    assign w_bin[1] = r_mag[1][BIN_W-1:0];

    for (genvar g = 2; g <= LAST_DABBLE; g++) begin : g_dabble
        num7seg_dabble #(
            .STEPS((g == LAST_DABBLE) ? DABBLE_STEPS_LAST : DABBLE_STEPS)
        ) u_dabble (
            .i_clk (i_clk),
            .i_en  (adv[g]),
            .i_bcd (w_bcd[g-1]),
            .i_bin (w_bin[g-1]),
            .o_bcd (w_bcd[g]),
            .o_bin (w_bin[g])
        );
    end

    // The scan limit doubles as the digit that carries the point.
    always_comb begin
        logic signed [6:0] limit;
        logic [3:0]        places;
        logic [3:0]        idx;
        logic              stop;
        logic [7:0]        seg;
        t_code             code [WORD_DIGITS];

        places = r_pp[LAST_DABBLE][4] ? 4'd0 : r_pp[LAST_DABBLE][3:0];
        limit  = $signed({3'b000, n_cnt}) - 7'sd1 - $signed({3'b000, places});
        n_word = '0;
        for (int k = 0; k < WORD_DIGITS; k++) begin
            idx = n_cnt - 4'd1 - 4'(k);
            if (!r_fits[LAST_DABBLE]) begin
                code[k] = CODE_DASH;
            end else if (r_neg[LAST_DABBLE] && k == 0) begin
                code[k] = CODE_DASH;
            end else if (r_hex[LAST_DABBLE]) begin
                code[k] = {1'b0, r_mag[LAST_DABBLE][4*idx[2:0] +: 4]};
            end else begin
                code[k] = {1'b0, w_bcd[LAST_DABBLE][4*idx[2:0] +: 4]};
            end
        end
        stop = 1'b0;
        for (int i = 0; i < WORD_DIGITS; i++) begin
            if (!r_zeros && r_fits[LAST_DABBLE] && !stop && $signed(7'(i)) < limit) begin
                if (code[i] == 5'd0) begin
                    code[i] = CODE_BLANK;
                end else if (code[i] != CODE_DASH) begin
                    stop = 1'b1;
                end
            end
        end
        for (int k = 0; k < WORD_DIGITS; k++) begin
            seg = glyph(code[k]);
            if (!r_pp[LAST_DABBLE][4] && $signed(7'(k)) == limit) begin
                seg = seg | SEG_POINT;
            end
            if (4'(k) < n_cnt) begin
                n_word[8*k +: 8] = seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTAGE]) begin
            r_word <= n_word;
        end
    end

    assign o_valid        = r_vld[NSTAGE];
    assign o_segment_word = r_word;

endmodule

@@ hw/rtl/num7seg_checker.sv @@
// Port-level checks for number_to_seven_segment, attached by the bind at the end of the file.
// Depends on num7seg_pkg and the top level's ports.
module num7seg_checker
    import num7seg_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [WORD_W-1:0]  o_segment_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_segment_word))
        else $error("Output beat changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output beat present right after reset.");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("Input stalled while the output stage is empty.");

    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_segment_word[63], o_segment_word[55], o_segment_word[47],
                              o_segment_word[39], o_segment_word[31], o_segment_word[23],
                              o_segment_word[15], o_segment_word[7]}))
        else $error("More than one decimal point lit.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        ##1 !i_stall |=> o_valid)
        else $error("Accepted beat did not reach the output in six cycles.");

endmodule

bind number_to_seven_segment num7seg_checker u_num7seg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_segment_word (o_segment_word)
);

@@ sim/number_to_seven_segment_test.sv @@
// Testbench for number_to_seven_segment: drives random and directed numbers under several
// register settings and handshake pressures, and checks every segment word against a
// scoreboard-held prediction. Depends on num7seg_pkg and the number_to_seven_segment RTL.
`timescale 1ns / 100ps

module number_to_seven_segment_test;
    import num7seg_pkg::*;

    localparam logic [7:0] GLYPH_ROM [0:17] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
        SEG_BLANK, SEG_DASH
    };

    class seg_word_board;
        logic [3:0]  digits_cfg;
        logic        lz_cfg;
        logic [63:0] pending_words [$];
        int          beats_in;
        int          beats_out;
        int          errors;

        function new();
            digits_cfg = 4'd4;
            lz_cfg     = 1'b0;
            beats_in   = 0;
            beats_out  = 0;
            errors     = 0;
        endfunction

        function void write_register(input t_reg_addr addr, input logic [3:0] data);
            if (addr == REG_DIGITS_IN_USE) begin
                digits_cfg = data;
            end else begin
                lz_cfg = data[0];
            end
        endfunction

        static function longint unsigned raise(input longint unsigned base, input int exp);
            longint unsigned p;
            p = 1;
            for (int i = 0; i < exp; i++) begin
                p = p * base;
            end
            return p;
        endfunction

        function logic [63:0] decode_segments(input logic [31:0] raw,
                                              input logic signed [4:0] point,
                                              input logic hex);
            bit              neg;
            bit              fits;
            bit              done;
            logic [31:0]     negated;
            longint unsigned mag;
            longint unsigned base;
            longint unsigned f;
            longint unsigned d;
            int              n;
            int              pp;
            int              places;
            int              limit;
            int              start;
            t_code           code [8];
            logic [7:0]      seg;
            logic [63:0]     word;
            neg     = raw[31];
            negated = ~raw + 32'd1;
            mag     = neg ? {32'd0, negated} : {32'd0, raw};
            pp      = int'(point);
            base    = hex ? 64'd16 : 64'd10;
            n       = int'(digits_cfg);
            if (n < 1) n = 1;
            if (n > 8) n = 8;
            if (neg) begin
                fits = mag <= raise(base, n - 1) - 1;
            end else begin
                fits = mag <= raise(base, n) - 1;
            end
            for (int k = 0; k < 8; k++) begin
                code[k] = CODE_BLANK;
            end
            if (!fits) begin
                for (int k = 0; k < n; k++) begin
                    code[k] = CODE_DASH;
                end
            end else begin
                start = 0;
                if (neg) begin
                    code[0] = CODE_DASH;
                    start   = 1;
                end
                for (int k = start; k < n; k++) begin
                    f       = raise(base, n - 1 - k);
                    d       = mag / f;
                    code[k] = {1'b0, d[3:0]};
                    mag     = mag - d * f;
                end
                if (!lz_cfg) begin
                    places = (pp < 0) ? 0 : pp;
                    limit  = n - 1 - places;
                    done   = 1'b0;
                    for (int i = 0; i < limit && !done; i++) begin
                        if (code[i] == 5'd0) begin
                            code[i] = CODE_BLANK;
                        end else if (code[i] < 5'd16) begin
                            done = 1'b1;
                        end
                    end
                end
            end
            word = '0;
            for (int k = 0; k < n; k++) begin
                seg = GLYPH_ROM[code[k]];
                if (pp >= 0 && k == n - 1 - pp) begin
                    seg = seg | SEG_POINT;
                end
                word = word | ({56'd0, seg} << (8 * k));
            end
            return word;
        endfunction

        function void note_input(input logic [31:0] value, input logic signed [4:0] point,
                                 input logic hex);
            pending_words.push_back(decode_segments(value, point, hex));
            beats_in++;
        endfunction

        function void check_word(input logic [63:0] word);
            logic [63:0] want;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: segment word %h arrived, expected none", $time, word);
                return;
            end
            want = pending_words.pop_front();
            beats_out++;
            if (want !== word) begin
                errors++;
                $display("%0t: segment word expected %h, actual %h", $time, want, word);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    t_reg_addr          i_cfg_addr;
    logic [3:0]         i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_value;
    logic signed [4:0]  i_point_position;
    logic               i_hex_mode;
    logic               o_valid;
    logic               i_stall;
    logic [WORD_W-1:0]  o_segment_word;

    seg_word_board board = new();
    int send_idle_pct;
    int stall_pct;
    int settings_used;

    localparam int PHASES = 12;
    localparam logic [3:0] PHASE_DIGITS [PHASES] = '{
        4'd1, 4'd8, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd9, 4'd2, 4'd6, 4'd7, 4'd4
    };
    localparam logic PHASE_LZ [PHASES] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
    };

    number_to_seven_segment i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_value          (i_value),
        .i_point_position (i_point_position),
        .i_hex_mode       (i_hex_mode),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_segment_word   (o_segment_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_input(i_value, i_point_position, i_hex_mode);
            end
            if (o_valid && !i_stall) begin
                board.check_word(o_segment_word);
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    task automatic send_beat(input logic [31:0] v, input logic [4:0] p, input logic h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_value          = v;
        i_point_position = p;
        i_hex_mode       = h;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_addr addr, input logic [3:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(posedge i_clk);
        board.write_register(addr, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (board.pending_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic int fitted_digits();
        int n;
        n = int'(board.digits_cfg);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic logic [31:0] pick_value(input logic hex, input int n);
        longint unsigned base;
        longint unsigned t;
        logic [31:0]     mag;
        logic [31:0]     v;
        int              m;
        base = hex ? 64'd16 : 64'd10;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: begin t = seg_word_board::raise(base, n) - 1; v = t[31:0]; end
                    1: begin t = seg_word_board::raise(base, n);     v = t[31:0]; end
                    2: begin t = seg_word_board::raise(base, n - 1) - 1; v = -t[31:0]; end
                    default: begin t = seg_word_board::raise(base, n - 1); v = -t[31:0]; end
                endcase
            end
            default: begin
                m   = $urandom_range(0, n);
                t   = {32'd0, $urandom};
                t   = t % seg_word_board::raise(base, m);
                mag = t[31:0];
                v   = ($urandom_range(0, 2) == 0) ? -mag : mag;
            end
        endcase
        return v;
    endfunction

    task automatic send_random();
        logic        hex;
        logic [4:0]  p;
        logic [31:0] v;
        int          n;
        hex = 1'($urandom_range(0, 1));
        n   = fitted_digits();
        v   = pick_value(hex, n);
        if ($urandom_range(0, 9) < 7) begin
            p = 5'($urandom_range(0, n) - 1);
        end else begin
            p = 5'($urandom);
        end
        send_beat(v, p, hex);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_addr       = REG_DIGITS_IN_USE;
        i_cfg_wdata      = 4'd0;
        i_valid          = 1'b0;
        i_value          = '0;
        i_point_position = '0;
        i_hex_mode       = 1'b0;
        settings_used    = 1;
        set_idling(0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset setting: four digits, leading zeros blanked.
        send_beat(32'd0, -5'sd1, 1'b0);
        send_beat(32'd1, 5'd0, 1'b0);
        send_beat(-32'sd1, -5'sd1, 1'b0);
        send_beat(32'd9999, -5'sd1, 1'b0);
        send_beat(32'd10000, -5'sd1, 1'b0);
        send_beat(-32'sd999, -5'sd1, 1'b0);
        send_beat(-32'sd1000, 5'd1, 1'b0);
        send_beat(32'h7FFF_FFFF, -5'sd1, 1'b0);
        send_beat(32'h8000_0000, -5'sd1, 1'b0);
        send_beat(32'd5, 5'd2, 1'b0);
        send_beat(32'd7, 5'd3, 1'b0);
        send_beat(32'd12, 5'd4, 1'b0);
        send_beat(32'd12, -5'sd16, 1'b0);
        send_beat(32'd12, 5'd15, 1'b0);
        send_beat(-32'sd5, 5'd1, 1'b0);
        send_beat(32'h0000_FFFF, -5'sd1, 1'b1);
        send_beat(32'h0001_0000, -5'sd1, 1'b1);
        send_beat(-32'sh0FFF, -5'sd1, 1'b1);
        send_beat(-32'sh1000, -5'sd1, 1'b1);
        send_beat(32'h0000_00A0, -5'sd1, 1'b1);
        send_beat(32'h0000_0B05, 5'd1, 1'b1);
        drain();
        write_reg(REG_DIGITS_IN_USE, 4'd8);
        settings_used++;
        send_beat(32'hFFFF_FFFF, -5'sd1, 1'b1);
        send_beat(32'h7FFF_FFFF, 5'd8, 1'b1);
        send_beat(-32'sd9999999, 5'd7, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_DIGITS_IN_USE, PHASE_DIGITS[ph]);
            write_reg(REG_SHOW_LEADING_ZEROS, {3'($urandom), PHASE_LZ[ph]});
            settings_used++;
            set_idling(ph % 4);
            for (int i = 0; i < 85; i++) begin
                send_random();
            end
            set_idling(0);
            drain();
        end

        repeat (20) @(negedge i_clk);
        $display("Checked %0d segment words from %0d input beats over %0d register settings,",
                 board.beats_out, board.beats_in, settings_used);
        $display("with idle sender, stalling receiver and combined pressure phases.");
        if (board.errors == 0 && board.pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
